### src/tms_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tms_pkg;

	// Default sizing of the selector.
	localparam int POP_MAX_DEF         = 256;
	localparam int MAX_COMPETITORS_DEF = 8;
	localparam int SCORE_BITS_DEF      = 16;

	// Fixed field widths of the item and result channels.
	localparam int ACTION_W = 2;
	localparam int INDEX_W  = 8;
	localparam int SCORE_W  = 16;
	localparam int STATUS_W = 3;

	// Configuration port.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;
	localparam int POP_W      = 9;
	localparam int TSIZE_W    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOURN_SIZE = 2'd1;

	localparam logic [POP_W-1:0]   POP_SIZE_RST   = 9'd256;
	localparam logic [TSIZE_W-1:0] TOURN_SIZE_RST = 4'd4;

	// Item actions.
	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_DRAW  = 2'd2
	} action_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_LOADED  = 3'd0,
		ST_STARTED = 3'd1,
		ST_REJECT  = 3'd2,
		ST_ACCEPT  = 3'd3,
		ST_WINNER  = 3'd4,
		ST_IGNORED = 3'd5
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;	// capture the item and start the score table read
		logic exec;	// evaluate the item and load the result register
	} tms_cmd_t;

endpackage

`default_nettype wire

### src/tms_item_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tms_item_if;
	import tms_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [INDEX_W-1:0]  index;
	logic [SCORE_W-1:0]  score;

	modport source (output valid, output action, output index, output score, input ready);
	modport sink (input valid, input action, input index, input score, output ready);
endinterface

`default_nettype wire

### src/tms_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tms_result_if;
	import tms_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [INDEX_W-1:0]  winner_index;
	logic [SCORE_W-1:0]  winner_score;

	modport source (output valid, output status, output winner_index, output winner_score,
		input ready);
	modport sink (input valid, input status, input winner_index, input winner_score,
		output ready);
endinterface

`default_nettype wire

### src/tournament_mate_selector.sv
// An accepted item is captured and evaluated once the result register is free;
// no new item is accepted until then. The registered score table read comes
// before the duplicate check and best-score compare of each item.
// Reset (arst_n low, asynchronous) clears the tournament state and sets
// pop_size to 256 and tournament_size to 4; the score table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module tournament_mate_selector #(
	parameter int POP_MAX         = tms_pkg::POP_MAX_DEF,
	parameter int MAX_COMPETITORS = tms_pkg::MAX_COMPETITORS_DEF,
	parameter int SCORE_BITS      = tms_pkg::SCORE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [tms_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tms_pkg::CFG_DATA_W-1:0] cfg_data,
	tms_item_if.sink                            items,
	tms_result_if.source                        results
);
	import tms_pkg::*;

	tms_cmd_t cmd;

	// Handshake sequencing.
	tms_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	// Score table, tournament state and result register.
	tms_dpath #(
		.POP_MAX         (POP_MAX),
		.MAX_COMPETITORS (MAX_COMPETITORS),
		.SCORE_BITS      (SCORE_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_action        (items.action),
		.in_index         (items.index),
		.in_score         (items.score),
		.out_status       (results.status),
		.out_winner_index (results.winner_index),
		.out_winner_score (results.winner_score)
	);
endmodule

`default_nettype wire

### src/tms_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tms_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output tms_pkg::tms_cmd_t     cmd
);
	import tms_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// The result register can take a new result when empty or being drained.
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign cmd.latch = in_valid && (state_q == S_IDLE);
	assign cmd.exec  = (state_q == S_EXEC) && out_free;

	// State and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

`default_nettype wire

### src/tms_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module tms_dpath #(
	parameter int POP_MAX         = tms_pkg::POP_MAX_DEF,
	parameter int MAX_COMPETITORS = tms_pkg::MAX_COMPETITORS_DEF,
	parameter int SCORE_BITS      = tms_pkg::SCORE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire tms_pkg::tms_cmd_t             cmd,
	input  wire logic                          cfg_we,
	input  wire logic [tms_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [tms_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [tms_pkg::ACTION_W-1:0]  in_action,
	input  wire logic [tms_pkg::INDEX_W-1:0]   in_index,
	input  wire logic [tms_pkg::SCORE_W-1:0]   in_score,
	output logic [tms_pkg::STATUS_W-1:0]       out_status,
	output logic [tms_pkg::INDEX_W-1:0]        out_winner_index,
	output logic [tms_pkg::SCORE_W-1:0]        out_winner_score
);
	import tms_pkg::*;

	// Table depth is bounded by what an 8-bit index can reach.
	localparam int TDEPTH = (POP_MAX < (1 << INDEX_W)) ? POP_MAX : (1 << INDEX_W);
	localparam int AW     = $clog2(TDEPTH);
	localparam int PW     = ($clog2(POP_MAX + 1) > POP_W) ? $clog2(POP_MAX + 1) : POP_W;
	localparam int CW     = $clog2(MAX_COMPETITORS + 1);
	localparam int LW     = (MAX_COMPETITORS > 1) ? $clog2(MAX_COMPETITORS) : 1;
	localparam int SB     = SCORE_BITS;

	// Configuration registers.
	logic [POP_W-1:0]   pop_q;
	logic [TSIZE_W-1:0] tsize_q;

	// Captured item.
	logic [ACTION_W-1:0] action_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [SCORE_W-1:0]  score_q;

	// Score table with registered read.
	logic [SB-1:0] table_mem [TDEPTH];
	logic [SB-1:0] rd_q;
	logic          tbl_we;
	logic [SB-1:0] tbl_wdata;
	logic [31:0]   score_ext;

	// Tournament state.
	logic [INDEX_W-1:0] list_q [MAX_COMPETITORS];
	logic [CW-1:0]      count_q;
	logic [INDEX_W-1:0] req_q;
	logic [SB-1:0]      best_score_q;
	logic               best_valid_q;
	logic [INDEX_W-1:0] best_idx_q;
	logic               active_q;

	// Result register.
	status_t            status_q;
	logic [INDEX_W-1:0] widx_q;
	logic [SCORE_W-1:0] wscore_q;

	// Evaluation signals.
	logic [PW-1:0] eff_pop;
	logic [PW-1:0] eff_size;
	logic [PW-1:0] idx_x;
	logic          dup;
	logic          do_start;
	logic          do_join;
	logic          take_best;
	logic          do_finish;
	logic [CW-1:0] count_inc;
	logic [SB-1:0] fin_score;
	logic [INDEX_W-1:0] fin_idx;
	logic          fin_valid;
	logic [31:0]   fin_ext;
	status_t       res_status;

	assign idx_x     = PW'(idx_q);
	assign count_inc = count_q + CW'(1);
	assign score_ext = 32'(score_q);
	assign tbl_wdata = score_ext[SB-1:0];

	// Effective population and tournament size from the registers.
	always_comb begin
		logic [PW-1:0] lim;
		eff_pop = PW'(pop_q);
		if (eff_pop < PW'(2)) begin
			eff_pop = PW'(2);
		end
		if (eff_pop > PW'(POP_MAX)) begin
			eff_pop = PW'(POP_MAX);
		end
		lim      = eff_pop - PW'(1);
		eff_size = PW'(tsize_q);
		if (eff_size == '0) begin
			eff_size = PW'(1);
		end
		if (eff_size > PW'(MAX_COMPETITORS)) begin
			eff_size = PW'(MAX_COMPETITORS);
		end
		if (eff_size > lim) begin
			eff_size = lim;
		end
	end

	// Duplicate check over the stored competitors.
	always_comb begin
		dup = 1'b0;
		for (int i = 0; i < MAX_COMPETITORS; i++) begin
			if ((CW'(i) < count_q) && (list_q[i] == idx_q)) begin
				dup = 1'b1;
			end
		end
	end

	// Item evaluation.
	always_comb begin
		tbl_we     = 1'b0;
		do_start   = 1'b0;
		do_join    = 1'b0;
		take_best  = 1'b0;
		do_finish  = 1'b0;
		res_status = ST_IGNORED;
		unique case (action_q)
			ACT_LOAD: begin
				if (idx_x < PW'(POP_MAX)) begin
					tbl_we     = 1'b1;
					res_status = ST_LOADED;
				end
			end
			ACT_START: begin
				do_start   = 1'b1;
				res_status = ST_STARTED;
			end
			ACT_DRAW: begin
				if (active_q) begin
					if (PW'(count_q) >= eff_size) begin
						do_finish  = 1'b1;
						res_status = ST_WINNER;
					end else if (idx_x >= eff_pop || idx_q == req_q || dup) begin
						res_status = ST_REJECT;
					end else begin
						do_join   = 1'b1;
						take_best = !best_valid_q || (rd_q > best_score_q);
						if (PW'(count_inc) >= eff_size) begin
							do_finish  = 1'b1;
							res_status = ST_WINNER;
						end else begin
							res_status = ST_ACCEPT;
						end
					end
				end
			end
			default: begin
				res_status = ST_IGNORED;
			end
		endcase
	end

	// Best competitor as it stands after this draw.
	assign fin_score = take_best ? rd_q : best_score_q;
	assign fin_idx   = take_best ? idx_q : best_idx_q;
	assign fin_valid = take_best || best_valid_q;
	assign fin_ext   = 32'(fin_score);

	// Score table port.
	always_ff @(posedge clk) begin
		if (cmd.exec && tbl_we) begin
			table_mem[idx_q[AW-1:0]] <= tbl_wdata;
		end
		if (cmd.latch) begin
			rd_q <= table_mem[in_index[AW-1:0]];
		end
	end

	// Item capture and result register.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= in_action;
			idx_q    <= in_index;
			score_q  <= in_score;
		end
		if (cmd.exec) begin
			status_q <= res_status;
			if (do_finish) begin
				widx_q   <= fin_idx;
				wscore_q <= fin_valid ? fin_ext[SCORE_W-1:0] : '0;
			end else begin
				widx_q   <= '0;
				wscore_q <= '0;
			end
		end
	end

	// Competitor list.
	always_ff @(posedge clk) begin
		if (cmd.exec && do_join) begin
			list_q[count_q[LW-1:0]] <= idx_q;
		end
	end

	// Configuration and tournament control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_q        <= POP_SIZE_RST;
			tsize_q      <= TOURN_SIZE_RST;
			count_q      <= '0;
			req_q        <= '0;
			best_score_q <= '0;
			best_valid_q <= 1'b0;
			best_idx_q   <= '0;
			active_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_POP_SIZE) begin
					pop_q <= cfg_data[POP_W-1:0];
				end else if (cfg_index == CFG_TOURN_SIZE) begin
					tsize_q <= cfg_data[TSIZE_W-1:0];
				end
			end
			if (cmd.exec) begin
				if (do_start) begin
					req_q        <= idx_q;
					count_q      <= '0;
					best_valid_q <= 1'b0;
					best_idx_q   <= '0;
					active_q     <= 1'b1;
				end
				if (do_join) begin
					count_q <= count_inc;
				end
				if (take_best) begin
					best_score_q <= rd_q;
					best_idx_q   <= idx_q;
					best_valid_q <= 1'b1;
				end
				if (do_finish) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	assign out_status       = status_q;
	assign out_winner_index = widx_q;
	assign out_winner_score = wscore_q;
endmodule

`default_nettype wire

### src/tms_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tms_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [tms_pkg::STATUS_W-1:0]  out_status,
	input wire logic [tms_pkg::INDEX_W-1:0]   out_winner_index,
	input wire logic [tms_pkg::SCORE_W-1:0]   out_winner_score
);
	import tms_pkg::*;

	// One item at a time: no transaction right after another.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted in the cycle after a transaction");

	// Winner fields are zero unless a winner is reported.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_status != ST_WINNER) |->
		(out_winner_index == '0 && out_winner_score == '0))
		else $error("winner fields set on a non-winner result");

	// A result stays offered until it is taken.
	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A stalled result keeps its payload.
	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		($stable(out_status) && $stable(out_winner_index) && $stable(out_winner_score)))
		else $error("stalled result changed");
endmodule

bind tournament_mate_selector tms_checker u_tms_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (items.valid),
	.in_ready         (items.ready),
	.out_valid        (results.valid),
	.out_ready        (results.ready),
	.out_status       (results.status),
	.out_winner_index (results.winner_index),
	.out_winner_score (results.winner_score)
);

`default_nettype wire
